>>> rtl/core/fsl_pkg.sv
// Shared types and constants for the force safety slew limiter.
// Used by the controller, the datapath and the top level; no dependencies.
package fsl_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int DT_BITS     = 16;
	localparam int SPIKE_LIMIT = 5;
	localparam int DIV_STEPS   = 32;

	typedef enum logic [1:0] {
		OP_MITIGATE  = 2'd0,
		OP_SLEW_SELF = 2'd1,
		OP_SLEW_GIVEN = 2'd2,
		OP_TRIGGER   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_WIN_DUR   = 3'd0,
		REG_GAIN      = 3'd1,
		REG_TAU       = 3'd2,
		REG_NORM_RATE = 3'd3,
		REG_REST_RATE = 3'd4,
		REG_WIN_RATE  = 3'd5,
		REG_INST_RATE = 3'd6,
		REG_SUST_RATE = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		MUL_GAIN = 3'd0,
		MUL_RATE = 3'd1,
		MUL_INST = 3'd2,
		MUL_SUST = 3'd3,
		MUL_EMA  = 3'd4
	} mul_sel_t;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_DECODE = 10'b0000000010,
		ST_MUL_A  = 10'b0000000100,
		ST_SCALE  = 10'b0000001000,
		ST_DIV    = 10'b0000010000,
		ST_MUL_E  = 10'b0000100000,
		ST_MUL_B  = 10'b0001000000,
		ST_MUL_C  = 10'b0010000000,
		ST_CMP    = 10'b0100000000,
		ST_FIN    = 10'b1000000000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     scale;
		logic     div_init;
		logic     div_step;
		logic     cmp;
		logic     commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic win_open;
		logic seeded;
	} sts_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647)
			sat32 = 32'sh7FFFFFFF;
		else if (v < -36'sd2147483648)
			sat32 = 32'sh80000000;
		else
			sat32 = v[31:0];
	endfunction

endpackage

>>> rtl/core/force_safety_slew_limiter.sv
// Force safety slew limiter, top level: one item in, one result item out.
// Steps: decode, then result (trigger, closed-window mitigate); decode, rate multiply,
// limit multiplies and compare (slew); decode, gain multiply and scale (mitigate in
// window; seeded adds a 32-step divider and EMA multiply). One item at a time: the next
// item is accepted once the result is registered, later while the result waits.
// Reset (arst_n, async low) loads register defaults and clears window and EMA state.
module force_safety_slew_limiter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [31:0] force_in,
	input  logic signed [31:0] current_force,
	input  logic [15:0]        dt,
	input  logic               restricted,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] force_out,
	output logic               window_active,
	output logic               window_started,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_addr,
	input  logic [31:0]        cfg_data
);

	fsl_pkg::cmd_t cmd;
	fsl_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	fsl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fsl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_valid      (cfg_valid),
		.cfg_addr       (cfg_addr),
		.cfg_data       (cfg_data),
		.op             (op),
		.force_in       (force_in),
		.current_force  (current_force),
		.dt             (dt),
		.restricted     (restricted),
		.force_out      (force_out),
		.window_active  (window_active),
		.window_started (window_started)
	);

endmodule

>>> rtl/core/fsl_ctrl.sv
// Sequencing state machine for the force safety slew limiter.
// Depends on fsl_pkg; drives the datapath by command struct.
module fsl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  fsl_pkg::sts_t  sts,
	output fsl_pkg::cmd_t  cmd
);

	fsl_pkg::state_t state_q, state_n;
	logic [4:0] cnt_q;
	logic       out_valid_q;
	logic       can_commit;

	assign can_commit = !out_valid_q || out_ready;
	assign in_ready   = (state_q == fsl_pkg::ST_IDLE);
	assign out_valid  = out_valid_q;

	// next state and commands
	always_comb begin
		state_n     = state_q;
		cmd         = '0;
		cmd.mul_sel = fsl_pkg::MUL_GAIN;
		case (state_q)
			fsl_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = fsl_pkg::ST_DECODE;
				end
			end
			fsl_pkg::ST_DECODE: begin
				if (sts.op == fsl_pkg::OP_TRIGGER ||
				    (sts.op == fsl_pkg::OP_MITIGATE && !sts.win_open))
					state_n = fsl_pkg::ST_FIN;
				else
					state_n = fsl_pkg::ST_MUL_A;
			end
			fsl_pkg::ST_MUL_A: begin
				cmd.mul_en = 1'b1;
				if (sts.op == fsl_pkg::OP_MITIGATE) begin
					cmd.mul_sel = fsl_pkg::MUL_GAIN;
					state_n     = fsl_pkg::ST_SCALE;
				end else begin
					cmd.mul_sel = fsl_pkg::MUL_RATE;
					state_n     = fsl_pkg::ST_MUL_B;
				end
			end
			fsl_pkg::ST_SCALE: begin
				cmd.scale    = 1'b1;
				cmd.div_init = 1'b1;
				state_n      = sts.seeded ? fsl_pkg::ST_DIV : fsl_pkg::ST_FIN;
			end
			fsl_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == 5'd0)
					state_n = fsl_pkg::ST_MUL_E;
			end
			fsl_pkg::ST_MUL_E: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = fsl_pkg::MUL_EMA;
				state_n     = fsl_pkg::ST_FIN;
			end
			fsl_pkg::ST_MUL_B: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = fsl_pkg::MUL_INST;
				state_n     = fsl_pkg::ST_MUL_C;
			end
			fsl_pkg::ST_MUL_C: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = fsl_pkg::MUL_SUST;
				state_n     = fsl_pkg::ST_CMP;
			end
			fsl_pkg::ST_CMP: begin
				cmd.cmp = 1'b1;
				state_n = fsl_pkg::ST_FIN;
			end
			fsl_pkg::ST_FIN: begin
				if (can_commit) begin
					cmd.commit = 1'b1;
					state_n    = fsl_pkg::ST_IDLE;
				end
			end
			default: state_n = fsl_pkg::ST_IDLE;
		endcase
	end

	// state, divide step counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fsl_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.div_init)
				cnt_q <= 5'(fsl_pkg::DIV_STEPS - 1);
			else if (cmd.div_step)
				cnt_q <= cnt_q - 5'd1;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/core/fsl_dp.sv
// Datapath: config registers, state, shared multiplier, restoring divider.
// Depends on fsl_pkg; controlled by fsl_ctrl through cmd_t / sts_t.
module fsl_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  fsl_pkg::cmd_t       cmd,
	output fsl_pkg::sts_t       sts,
	input  logic                cfg_valid,
	input  logic [2:0]          cfg_addr,
	input  logic [31:0]         cfg_data,
	input  logic [1:0]          op,
	input  logic signed [31:0]  force_in,
	input  logic signed [31:0]  current_force,
	input  logic [15:0]         dt,
	input  logic                restricted,
	output logic signed [31:0]  force_out,
	output logic                window_active,
	output logic                window_started
);

	// configuration
	logic [21:0] win_dur_q;
	logic [16:0] gain_q;
	logic [19:0] tau_q;
	logic [30:0] norm_rate_q, rest_rate_q, inst_rate_q, sust_rate_q;
	logic [22:0] win_rate_q;

	// block state
	logic [31:0]        timer_q;
	logic signed [31:0] smoothed_q;
	logic               seeded_q;
	logic [2:0]         spike_q;

	// item registers
	fsl_pkg::op_t       op_q;
	logic signed [31:0] force_q, given_q;
	logic [15:0]        dt_q;
	logic               restr_q;

	// working registers
	logic signed [50:0] prod_q;
	logic signed [31:0] scaled_q, present_q;
	logic signed [32:0] delta_q, clamp_q;
	logic [30:0]        maxd_q;
	logic [46:0]        inst_q;
	logic               fast_i_q, fast_s_q;
	logic [20:0]        den_q, rem_q;
	logic [31:0]        quo_q;

	logic               win_open;
	logic [30:0]        rate;
	logic signed [32:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [32:0] ema_diff;
	logic [16:0]        alpha;
	logic signed [31:0] present_n;
	logic [21:0]        trial;
	logic [31:0]        mag;
	logic [47:0]        mag_sc;
	logic signed [32:0] maxd_s;
	logic [31:0]        step;

	assign win_open = (timer_q != 32'd0);
	assign sts.op       = op_q;
	assign sts.win_open = win_open;
	assign sts.seeded   = seeded_q;

	// slew rate selection
	always_comb begin
		rate = restr_q ? rest_rate_q : norm_rate_q;
		if (win_open && win_rate_q != 23'd0)
			rate = {8'd0, win_rate_q};
	end

	assign ema_diff  = 33'(scaled_q) - 33'(smoothed_q);
	assign alpha     = (den_q == 21'd0) ? 17'd0 : quo_q[16:0];
	assign present_n = (op_q == fsl_pkg::OP_SLEW_SELF) ? smoothed_q : given_q;

	// shared multiplier operand selection
	always_comb begin
		mul_a = 33'(force_q);
		mul_b = {1'b0, gain_q};
		case (cmd.mul_sel)
			fsl_pkg::MUL_GAIN: begin
				mul_a = 33'(force_q);
				mul_b = {1'b0, gain_q};
			end
			fsl_pkg::MUL_RATE: begin
				mul_a = {2'b00, rate};
				mul_b = {2'b00, dt_q};
			end
			fsl_pkg::MUL_INST: begin
				mul_a = {2'b00, inst_rate_q};
				mul_b = {2'b00, dt_q};
			end
			fsl_pkg::MUL_SUST: begin
				mul_a = {2'b00, sust_rate_q};
				mul_b = {2'b00, dt_q};
			end
			fsl_pkg::MUL_EMA: begin
				mul_a = ema_diff;
				mul_b = {1'b0, alpha};
			end
			default: begin
				mul_a = 33'(force_q);
				mul_b = {1'b0, gain_q};
			end
		endcase
	end

	// divider trial, step compare helpers
	assign trial  = {rem_q, quo_q[31]};
	assign mag    = delta_q[32] ? 32'(-delta_q) : delta_q[31:0];
	assign mag_sc = {mag, 16'd0};
	assign maxd_s = {2'b00, maxd_q};
	assign step   = 32'(({16'd0, dt_q} << fsl_pkg::FRAC_BITS) >> fsl_pkg::DT_BITS);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_dur_q   <= 22'd131072;
			gain_q      <= 17'd32768;
			tau_q       <= 20'd13107;
			norm_rate_q <= 31'd65536000;
			rest_rate_q <= 31'd6553600;
			win_rate_q  <= 23'd0;
			inst_rate_q <= 31'd32768000;
			sust_rate_q <= 31'd6553600;
		end else if (cfg_valid) begin
			case (fsl_pkg::reg_idx_t'(cfg_addr))
				fsl_pkg::REG_WIN_DUR:   win_dur_q   <= cfg_data[21:0];
				fsl_pkg::REG_GAIN:      gain_q      <= cfg_data[16:0];
				fsl_pkg::REG_TAU:       tau_q       <= cfg_data[19:0];
				fsl_pkg::REG_NORM_RATE: norm_rate_q <= cfg_data[30:0];
				fsl_pkg::REG_REST_RATE: rest_rate_q <= cfg_data[30:0];
				fsl_pkg::REG_WIN_RATE:  win_rate_q  <= cfg_data[22:0];
				fsl_pkg::REG_INST_RATE: inst_rate_q <= cfg_data[30:0];
				fsl_pkg::REG_SUST_RATE: sust_rate_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// working registers (no reset)
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= fsl_pkg::op_t'(op);
			force_q <= force_in;
			given_q <= current_force;
			dt_q    <= dt;
			restr_q <= restricted;
		end
		if (cmd.mul_en)
			prod_q <= 51'(mul_a * mul_b);
		if (cmd.mul_en && cmd.mul_sel == fsl_pkg::MUL_RATE) begin
			present_q <= present_n;
			delta_q   <= 33'(force_q) - 33'(present_n);
		end
		if (cmd.mul_en && cmd.mul_sel == fsl_pkg::MUL_INST)
			maxd_q <= prod_q[46:16];
		if (cmd.mul_en && cmd.mul_sel == fsl_pkg::MUL_SUST)
			inst_q <= prod_q[46:0];
		if (cmd.scale)
			scaled_q <= fsl_pkg::sat32(36'(prod_q >>> 16));
		// restoring divide: alpha = dt*2^16 / (tau + dt)
		if (cmd.div_init) begin
			den_q <= 21'(tau_q) + 21'(dt_q);
			rem_q <= '0;
			quo_q <= {dt_q, 16'd0};
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= 21'(trial - {1'b0, den_q});
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[20:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		// spike compare and step clamp
		if (cmd.cmp) begin
			fast_i_q <= (mag_sc > {1'b0, inst_q});
			fast_s_q <= (mag_sc > prod_q[47:0]);
			if (delta_q > maxd_s)
				clamp_q <= maxd_s;
			else if (delta_q < -maxd_s)
				clamp_q <= -maxd_s;
			else
				clamp_q <= delta_q;
		end
	end

	// commit: block state and result item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q    <= '0;
			smoothed_q <= '0;
			seeded_q   <= 1'b0;
			spike_q    <= '0;
		end else if (cmd.commit) begin
			case (op_q)
				fsl_pkg::OP_MITIGATE: begin
					if (win_open) begin
						if (!seeded_q) begin
							smoothed_q <= scaled_q;
							seeded_q   <= 1'b1;
						end else begin
							smoothed_q <= fsl_pkg::sat32(36'(smoothed_q) +
								36'(prod_q >>> 16));
						end
						timer_q <= (timer_q > step) ? timer_q - step : 32'd0;
					end
				end
				fsl_pkg::OP_TRIGGER: begin
					timer_q  <= 32'(win_dur_q);
					seeded_q <= 1'b0;
					spike_q  <= '0;
				end
				default: begin
					if (fast_i_q || (fast_s_q &&
					    (spike_q + 3'd1) >= 3'(fsl_pkg::SPIKE_LIMIT))) begin
						timer_q  <= 32'(win_dur_q);
						seeded_q <= 1'b0;
						spike_q  <= '0;
					end else if (fast_s_q)
						spike_q <= spike_q + 3'd1;
					else if (spike_q != 3'd0)
						spike_q <= spike_q - 3'd1;
					if (op_q == fsl_pkg::OP_SLEW_SELF)
						smoothed_q <= fsl_pkg::sat32(36'(present_q) + 36'(clamp_q));
				end
			endcase
		end
	end

	// result item registers
	logic signed [31:0] smooth_res;
	logic [31:0]        timer_res;
	logic               started_res;
	always_comb begin
		smooth_res  = force_q;
		timer_res   = timer_q;
		started_res = 1'b0;
		case (op_q)
			fsl_pkg::OP_MITIGATE: begin
				if (win_open) begin
					smooth_res = seeded_q ?
						fsl_pkg::sat32(36'(smoothed_q) + 36'(prod_q >>> 16)) : scaled_q;
					timer_res = (timer_q > step) ? timer_q - step : 32'd0;
				end
			end
			fsl_pkg::OP_TRIGGER: begin
				smooth_res  = '0;
				timer_res   = 32'(win_dur_q);
				started_res = 1'b1;
			end
			default: begin
				smooth_res = fsl_pkg::sat32(36'(present_q) + 36'(clamp_q));
				if (fast_i_q || (fast_s_q &&
				    (spike_q + 3'd1) >= 3'(fsl_pkg::SPIKE_LIMIT))) begin
					timer_res   = 32'(win_dur_q);
					started_res = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			force_out      <= smooth_res;
			window_active  <= (timer_res != 32'd0);
			window_started <= started_res;
		end
	end

endmodule

>>> rtl/core/fsl_checker.sv
// Port-level checks for the force safety slew limiter, bound to the top level.
// Depends only on the top level's ports.
module fsl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] force_out,
	input logic        window_active,
	input logic        window_started
);

	// one item at a time: accepting an item closes the input
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input still ready after an item was accepted");

	// a new result appears only as the block returns to idle
	a_rose_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while an item is still in work");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(force_out) &&
			$stable(window_active) && $stable(window_started)))
		else $error("stalled result item changed");

endmodule

bind force_safety_slew_limiter fsl_checker u_fsl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.force_out      (force_out),
	.window_active  (window_active),
	.window_started (window_started)
);
